// ===== rtl/core/rb2d_pkg.sv =====
// Shared types, codes and fixed-point helpers for the 2D rigid body stepper.
`timescale 1ns / 1ps

package rb2d_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // Operation codes carried on req_tuser
   localparam logic [2:0] OP_ADD_FORCE   = 3'd0;
   localparam logic [2:0] OP_ADD_IMPULSE = 3'd1;
   localparam logic [2:0] OP_TICK        = 3'd2;
   localparam logic [2:0] OP_SET_VEL     = 3'd3;
   localparam logic [2:0] OP_SET_POS     = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SAT       = 2'd1;
   localparam logic [1:0] STATUS_ZERO_MASS = 2'd2;

   // Configuration register indexes
   localparam logic CSR_MASS      = 1'b0;
   localparam logic CSR_ANG_ACCEL = 1'b1;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LD_AX,
      ST_LD_AY,
      ST_IMP_X,
      ST_IMP_Y,
      ST_DOM,
      ST_OMG,
      ST_SUM_X,
      ST_SUM_Y,
      ST_POS_X,
      ST_POS_Y,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic        done;
      logic        sat;
      logic [31:0] quo_x;
      logic [31:0] quo_y;
   } div_res_type;

   function automatic logic ovf32(input logic signed [63:0] v);
      return (v > 64'(S32_MAX)) || (v < 64'(S32_MIN));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(S32_MAX)) begin
         r = S32_MAX;
      end else if (v < 64'(S32_MIN)) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // arithmetic right shift rounding toward zero
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] p,
                                                   input logic [4:0] sh);
      logic signed [63:0] bias;
      bias = p[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (p + bias) >>> sh;
   endfunction

endpackage

// ===== rtl/core/rb2d_div.sv =====
// Two-lane restoring divider: (force << FRAC_BITS) / mass for x and y, saturated.
`timescale 1ns / 1ps

module rb2d_div #(
   parameter int FRAC_BITS = rb2d_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [31:0]        force_x,
   input  logic signed [31:0]        force_y,
   input  logic [30:0]               mass,
   output rb2d_pkg::div_res_type     res
);
   import rb2d_pkg::*;

   localparam int DIV_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff [2];
   logic             neg_in [2];
   logic [DIV_W-1:0] num_ff [2];
   logic [DIV_W-1:0] num_in [2];
   logic [31:0]      rem_ff [2];
   logic [31:0]      rem_in [2];
   logic [31:0]      quo    [2];
   logic             lsat   [2];
   logic signed [31:0] fin  [2];

   assign fin[0] = force_x;
   assign fin[1] = force_y;

   always_comb begin
      logic [31:0] t;
      logic [32:0] diff;
      logic [31:0] mag;
      logic [DIV_W-1:0] q;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      for (int l = 0; l < 2; l++) begin
         neg_in[l] = neg_ff[l];
         num_in[l] = num_ff[l];
         rem_in[l] = rem_ff[l];
         t    = {rem_ff[l][30:0], num_ff[l][DIV_W-1]};
         diff = {1'b0, t} - {2'b00, mass};
         mag  = fin[l][31] ? 32'(-fin[l]) : 32'(fin[l]);
         if (start) begin
            neg_in[l] = fin[l][31];
            num_in[l] = {mag, {FRAC_BITS{1'b0}}};
            rem_in[l] = '0;
         end else if (busy_ff && (cnt_ff != '0)) begin
            rem_in[l] = diff[32] ? t : diff[31:0];
            num_in[l] = {num_ff[l][DIV_W-2:0], ~diff[32]};
         end
         // saturate the magnitude into the signed 32-bit range
         q = num_ff[l];
         if (neg_ff[l]) begin
            lsat[l] = (|q[DIV_W-1:32]) || (q[31] && (|q[30:0]));
            quo[l]  = lsat[l] ? S32_MIN : (32'd0 - q[31:0]);
         end else begin
            lsat[l] = |q[DIV_W-1:31];
            quo[l]  = lsat[l] ? S32_MAX : q[31:0];
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      for (int l = 0; l < 2; l++) begin
         neg_ff[l] <= neg_in[l];
         num_ff[l] <= num_in[l];
         rem_ff[l] <= rem_in[l];
      end
   end

   assign res.done  = busy_ff && (cnt_ff == '0);
   assign res.sat   = lsat[0] | lsat[1];
   assign res.quo_x = quo[0];
   assign res.quo_y = quo[1];

endmodule

// ===== rtl/core/rigid_body_2d_step.sv =====
// Top level: 2D rigid body state and the tick sequencer around one shared multiplier.
`timescale 1ns / 1ps

// One 2D body in signed fixed point with FRAC_BITS fraction bits. Each request beat
// (op on req_tuser) yields one response beat holding the body state after it. Add force,
// add impulse, set velocity and set centroid go from the accept straight to the done
// step, which loads the response register and returns to idle. A tick runs the force /
// mass division for x and y side by side in a restoring divider (skipped when mass is
// zero), then ten steps on one 33x32 multiplier whose operand always pairs with the
// time step. req_tready is high only while the sequencer is idle; a finished result
// sits in the response register and does not hold off the next request, but the next
// item waits in its last step until that beat is taken. mass and angular_accel are to
// be written through the csr_ port only while the block is idle; the block itself does
// not enforce this.
module rigid_body_2d_step #(
   parameter int FRAC_BITS = rb2d_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // vec_x, vec_y, time_step, zero pad
   input  logic [2:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,   // pos_x, pos_y, vel_x, vel_y, heading, spin_rate,
                                     // status, zero pad
   input  logic         csr_wr_en,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wr_data
);
   import rb2d_pkg::*;

   localparam logic [4:0] SH1 = 5'(FRAC_BITS);
   localparam logic [4:0] SH2 = 5'(FRAC_BITS + 1);

   seq_state_type state_ff, state_in;

   logic [30:0]        mass_ff;
   logic signed [31:0] alpha_ff;

   logic signed [31:0] centroid_x_ff, centroid_x_in, centroid_y_ff, centroid_y_in;
   logic signed [31:0] velocity_x_ff, velocity_x_in, velocity_y_ff, velocity_y_in;
   logic signed [31:0] force_x_ff, force_x_in, force_y_ff, force_y_in;
   logic signed [31:0] impulse_x_ff, impulse_x_in, impulse_y_ff, impulse_y_in;
   logic signed [31:0] angle_ff, angle_in, omega_ff, omega_in;

   logic [30:0]        dt_ff, dt_in;
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [31:0] v2x_ff, v2x_in, v2y_ff, v2y_in;
   logic signed [63:0] dom_ff, dom_in, acc_ff, acc_in;
   logic signed [32:0] mul_a_ff, mul_a_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [64:0] mul_full;
   logic               sat_ff, sat_in, zero_mass_ff, zero_mass_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [199:0]       rsp_data_ff, rsp_data_in;

   logic               div_start;
   div_res_type        div_res;

   logic [2:0]         req_op;
   logic signed [31:0] req_vx, req_vy;
   logic [30:0]        req_dt;

   assign req_op = req_tuser;
   assign req_vx = req_tdata[31:0];
   assign req_vy = req_tdata[63:32];
   assign req_dt = req_tdata[94:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rb2d_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .force_x (force_x_ff),
      .force_y (force_y_ff),
      .mass    (mass_ff),
      .res     (div_res)
   );

   // shared multiplier: operand times time step, registered
   assign mul_full = mul_a_ff * $signed({1'b0, dt_ff});
   assign prod_in  = mul_full[63:0];

   always_comb begin
      logic signed [63:0] sum_a, sum_b;
      state_in      = state_ff;
      centroid_x_in = centroid_x_ff;
      centroid_y_in = centroid_y_ff;
      velocity_x_in = velocity_x_ff;
      velocity_y_in = velocity_y_ff;
      force_x_in    = force_x_ff;
      force_y_in    = force_y_ff;
      impulse_x_in  = impulse_x_ff;
      impulse_y_in  = impulse_y_ff;
      angle_in      = angle_ff;
      omega_in      = omega_ff;
      dt_in         = dt_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      v2x_in        = v2x_ff;
      v2y_in        = v2y_ff;
      dom_in        = dom_ff;
      acc_in        = acc_ff;
      mul_a_in      = mul_a_ff;
      sat_in        = sat_ff;
      zero_mass_in  = zero_mass_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;
      sum_a         = '0;
      sum_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sat_in       = 1'b0;
               zero_mass_in = 1'b0;
               dt_in        = req_dt;
               state_in     = ST_DONE;
               case (req_op)
                  OP_ADD_FORCE: begin
                     sum_a      = 64'(force_x_ff) + 64'(req_vx);
                     sum_b      = 64'(force_y_ff) + 64'(req_vy);
                     force_x_in = sat32(sum_a);
                     force_y_in = sat32(sum_b);
                     sat_in     = ovf32(sum_a) | ovf32(sum_b);
                  end
                  OP_ADD_IMPULSE: begin
                     sum_a        = 64'(impulse_x_ff) + 64'(req_vx);
                     sum_b        = 64'(impulse_y_ff) + 64'(req_vy);
                     impulse_x_in = sat32(sum_a);
                     impulse_y_in = sat32(sum_b);
                     sat_in       = ovf32(sum_a) | ovf32(sum_b);
                  end
                  OP_SET_VEL: begin
                     velocity_x_in = req_vx;
                     velocity_y_in = req_vy;
                  end
                  OP_SET_POS: begin
                     centroid_x_in = req_vx;
                     centroid_y_in = req_vy;
                  end
                  OP_TICK: begin
                     if (mass_ff == '0) begin
                        zero_mass_in = 1'b1;
                        ax_in        = '0;
                        ay_in        = '0;
                        state_in     = ST_LD_AX;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               ax_in    = div_res.quo_x;
               ay_in    = div_res.quo_y;
               sat_in   = sat_ff | div_res.sat;
               state_in = ST_LD_AX;
            end
         end
         // an operand loaded in one step is registered in mul_a_ff and its product in prod_ff before use
         ST_LD_AX: begin
            mul_a_in = 33'(ax_ff);
            state_in = ST_LD_AY;
         end
         ST_LD_AY: begin
            mul_a_in = 33'(ay_ff);
            state_in = ST_IMP_X;
         end
         ST_IMP_X: begin
            sum_a        = 64'(impulse_x_ff) + trunc_shr(prod_ff, SH1);
            impulse_x_in = sat32(sum_a);
            sat_in       = sat_ff | ovf32(sum_a);
            mul_a_in     = 33'(alpha_ff);
            state_in     = ST_IMP_Y;
         end
         ST_IMP_Y: begin
            sum_a        = 64'(impulse_y_ff) + trunc_shr(prod_ff, SH1);
            impulse_y_in = sat32(sum_a);
            sat_in       = sat_ff | ovf32(sum_a);
            mul_a_in     = 33'(omega_ff);
            state_in     = ST_DOM;
         end
         ST_DOM: begin
            dom_in   = trunc_shr(prod_ff, SH1);
            sum_a    = 64'(velocity_x_ff) + 64'(impulse_x_ff);
            v2x_in   = sat32(sum_a);
            sat_in   = sat_ff | ovf32(sum_a);
            state_in = ST_OMG;
         end
         ST_OMG: begin
            acc_in   = 64'(angle_ff) + trunc_shr(prod_ff, SH1);
            sum_a    = 64'(velocity_y_ff) + 64'(impulse_y_ff);
            v2y_in   = sat32(sum_a);
            // clamped rate change feeds the quadratic angle term
            mul_a_in = 33'(sat32(dom_ff));
            sat_in   = sat_ff | ovf32(sum_a) | ovf32(dom_ff);
            state_in = ST_SUM_X;
         end
         ST_SUM_X: begin
            mul_a_in = 33'(velocity_x_ff) + 33'(v2x_ff);
            sum_a    = 64'(omega_ff) + dom_ff;
            omega_in = sat32(sum_a);
            sat_in   = sat_ff | ovf32(sum_a);
            state_in = ST_SUM_Y;
         end
         ST_SUM_Y: begin
            mul_a_in = 33'(velocity_y_ff) + 33'(v2y_ff);
            sum_a    = acc_ff + trunc_shr(prod_ff, SH2);
            angle_in = sat32(sum_a);
            sat_in   = sat_ff | ovf32(sum_a);
            state_in = ST_POS_X;
         end
         ST_POS_X: begin
            sum_a         = 64'(centroid_x_ff) + trunc_shr(prod_ff, SH2);
            centroid_x_in = sat32(sum_a);
            velocity_x_in = v2x_ff;
            sat_in        = sat_ff | ovf32(sum_a);
            state_in      = ST_POS_Y;
         end
         ST_POS_Y: begin
            sum_a         = 64'(centroid_y_ff) + trunc_shr(prod_ff, SH2);
            centroid_y_in = sat32(sum_a);
            velocity_y_in = v2y_ff;
            sat_in        = sat_ff | ovf32(sum_a);
            force_x_in    = '0;
            force_y_in    = '0;
            impulse_x_in  = '0;
            impulse_y_in  = '0;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0,
                               zero_mass_ff ? STATUS_ZERO_MASS :
                               (sat_ff ? STATUS_SAT : STATUS_OK),
                               omega_ff, angle_ff, velocity_y_ff, velocity_x_ff,
                               centroid_y_ff, centroid_x_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mass_ff       <= 31'd65536;
         alpha_ff      <= '0;
         centroid_x_ff <= '0;
         centroid_y_ff <= '0;
         velocity_x_ff <= '0;
         velocity_y_ff <= '0;
         force_x_ff    <= '0;
         force_y_ff    <= '0;
         impulse_x_ff  <= '0;
         impulse_y_ff  <= '0;
         angle_ff      <= '0;
         omega_ff      <= '0;
         sat_ff        <= 1'b0;
         zero_mass_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         centroid_x_ff <= centroid_x_in;
         centroid_y_ff <= centroid_y_in;
         velocity_x_ff <= velocity_x_in;
         velocity_y_ff <= velocity_y_in;
         force_x_ff    <= force_x_in;
         force_y_ff    <= force_y_in;
         impulse_x_ff  <= impulse_x_in;
         impulse_y_ff  <= impulse_y_in;
         angle_ff      <= angle_in;
         omega_ff      <= omega_in;
         sat_ff        <= sat_in;
         zero_mass_ff  <= zero_mass_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_MASS:      mass_ff  <= csr_wr_data[30:0];
               CSR_ANG_ACCEL: alpha_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      dt_ff       <= dt_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      v2x_ff      <= v2x_in;
      v2y_ff      <= v2y_in;
      dom_ff      <= dom_in;
      acc_ff      <= acc_in;
      mul_a_ff    <= mul_a_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // divider result only ever arrives while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the division step");

   // a tick leaves no force or impulse behind
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS_Y) |=> (force_x_ff == '0 && force_y_ff == '0 &&
                                  impulse_x_ff == '0 && impulse_y_ff == '0))
      else $error("force or impulse survived a tick");

   // zero mass status only when mass really is zero
   a_zero_mass_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[193:192] == STATUS_ZERO_MASS) |-> (mass_ff == '0))
      else $error("zero mass reported with nonzero mass");

endmodule
